// ----- sv/two_class_ticket_queue_wrr_core_macros.svh -----
// ----------------------------------------------------------------------------
// two_class_ticket_queue_wrr_core_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_TICKET_QUEUE_WRR_CORE_MACROS_SVH
`define TWO_CLASS_TICKET_QUEUE_WRR_CORE_MACROS_SVH

// same-cycle implication
`define TCTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tctq assertion failed");

// next-cycle implication
`define TCTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tctq assertion failed");

`endif

// ----- sv/tctq_pkg.sv -----
// ----------------------------------------------------------------------------
// tctq_pkg
// Shared types and codes of the two-class ticket queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tctq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PREFERRED_RUN_DEF = 2;
    localparam int TICKET_W          = 16;
    localparam int CMD_W             = 2;
    localparam int STATUS_W          = 2;

    localparam logic [CMD_W-1:0] CMD_ENQ_NORMAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQ_PREF   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_EMIT    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ACCEPT  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

    typedef enum logic
    {
        S_IDLE,
        S_DRAIN
    } state_t;

endpackage

`default_nettype wire

// ----- sv/tctq_ticket_ram.sv -----
// ----------------------------------------------------------------------------
// tctq_ticket_ram
// Ticket store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tctq_ticket_ram #(
    parameter int DEPTH = tctq_pkg::QUEUE_DEPTH_DEF,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AddrW-1:0]              wr_addr,
    input  wire logic [tctq_pkg::TICKET_W-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AddrW-1:0]              rd_addr,
    output logic      [tctq_pkg::TICKET_W-1:0] rd_data
);

    logic [tctq_pkg::TICKET_W-1:0] mem [DEPTH];
    logic [tctq_pkg::TICKET_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/two_class_ticket_queue_wrr_core.sv -----
// ----------------------------------------------------------------------------
// two_class_ticket_queue_wrr_core
// Normal and preferential ticket FIFOs with a weighted round-robin drain.
// ----------------------------------------------------------------------------
// An enqueue request (tuser 0 normal, 1 preferential) is answered by one
// response in the next cycle and can be taken every cycle while responses are
// taken. A drain request (tuser 2) emits every held ticket, PREFERRED_RUN
// preferential then one normal, one per cycle while the output takes them,
// out of the two ticket RAMs through their registered read stage; tready
// stays low until the last ticket has left that stage. Both queues are empty
// afterwards. A drain of two empty queues gives one response with status 3.
// tuser 3 is taken and ignored. Output stalls are absorbed by the response
// register and the RAM read stage.
`timescale 1ns / 1ps
`default_nettype none

module two_class_ticket_queue_wrr_core #(
    parameter int QUEUE_DEPTH   = tctq_pkg::QUEUE_DEPTH_DEF,
    parameter int PREFERRED_RUN = tctq_pkg::PREFERRED_RUN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] ticket
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [15:0] ticket_out
    output logic      [2:0]  m_axis_tuser,   // [1:0] status, [2] preferential
    output logic             m_axis_tlast
);

    localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int SumW = CntW + 1;
    localparam int RunW = $clog2(PREFERRED_RUN + 1);

    tctq_pkg::state_t state_reg, state_next;

    logic [IdxW-1:0] n_head_reg, n_head_next, p_head_reg, p_head_next;
    logic [CntW-1:0] n_cnt_reg, n_cnt_next, p_cnt_reg, p_cnt_next;
    logic [RunW-1:0] run_reg, run_next;

    logic pend_valid_reg, pend_valid_next;
    logic pend_pref_reg, pend_pref_next;
    logic pend_last_reg, pend_last_next;

    logic                               out_valid_reg, out_valid_next;
    logic [tctq_pkg::STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [tctq_pkg::TICKET_W-1:0]      out_ticket_reg, out_ticket_next;
    logic                               out_pref_reg, out_pref_next;
    logic                               out_last_reg, out_last_next;

    logic can_load, in_ready, issue, accept, direct_resp;
    logic take_pref, last_pop, queues_empty;
    logic n_full, p_full;
    logic [SumW-1:0] n_sum, p_sum;
    logic [IdxW-1:0] n_wr_addr, p_wr_addr;
    logic n_wr_en, p_wr_en, n_rd_en, p_rd_en;
    logic [tctq_pkg::TICKET_W-1:0] n_rd_data, p_rd_data;

    assign can_load     = !out_valid_reg || m_axis_tready;
    assign accept       = s_axis_tvalid && in_ready;
    assign queues_empty = (n_cnt_reg == '0) && (p_cnt_reg == '0);
    assign n_full       = (n_cnt_reg == CntW'(QUEUE_DEPTH));
    assign p_full       = (p_cnt_reg == CntW'(QUEUE_DEPTH));

    // enqueues and a drain of empty queues answer at once
    assign direct_resp = accept && (s_axis_tuser != tctq_pkg::CMD_UNUSED)
        && ((s_axis_tuser != tctq_pkg::CMD_DRAIN) || queues_empty);

    assign take_pref = (p_cnt_reg != '0)
        && ((run_reg < RunW'(PREFERRED_RUN)) || (n_cnt_reg == '0));
    assign last_pop = take_pref ? ((p_cnt_reg == CntW'(1)) && (n_cnt_reg == '0))
                                : ((n_cnt_reg == CntW'(1)) && (p_cnt_reg == '0));

    // tail index: head + count wraps at most once
    assign n_sum = SumW'(n_head_reg) + SumW'(n_cnt_reg);
    assign p_sum = SumW'(p_head_reg) + SumW'(p_cnt_reg);
    assign n_wr_addr = (n_sum >= SumW'(QUEUE_DEPTH)) ? IdxW'(n_sum - SumW'(QUEUE_DEPTH))
                                                     : IdxW'(n_sum);
    assign p_wr_addr = (p_sum >= SumW'(QUEUE_DEPTH)) ? IdxW'(p_sum - SumW'(QUEUE_DEPTH))
                                                     : IdxW'(p_sum);

    assign n_wr_en = accept && (s_axis_tuser == tctq_pkg::CMD_ENQ_NORMAL) && !n_full;
    assign p_wr_en = accept && (s_axis_tuser == tctq_pkg::CMD_ENQ_PREF) && !p_full;
    assign n_rd_en = issue && !take_pref;
    assign p_rd_en = issue && take_pref;

    // writes happen only outside a drain, so no read can meet a pending write
    tctq_ticket_ram #(.DEPTH(QUEUE_DEPTH)) u_normal_ram (
        .clk     (clk),
        .wr_en   (n_wr_en),
        .wr_addr (n_wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (n_rd_en),
        .rd_addr (n_head_reg),
        .rd_data (n_rd_data)
    );

    tctq_ticket_ram #(.DEPTH(QUEUE_DEPTH)) u_pref_ram (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (p_wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (p_rd_en),
        .rd_addr (p_head_reg),
        .rd_data (p_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tctq_pkg::S_IDLE:
            begin
                if (accept && (s_axis_tuser == tctq_pkg::CMD_DRAIN) && !queues_empty)
                begin
                    state_next = tctq_pkg::S_DRAIN;
                end
            end
            tctq_pkg::S_DRAIN:
            begin
                if (issue && last_pop)
                begin
                    state_next = tctq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tctq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            tctq_pkg::S_IDLE:  in_ready = can_load && !pend_valid_reg;
            tctq_pkg::S_DRAIN: issue    = !pend_valid_reg || can_load;
            default:           in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        n_head_next     = n_head_reg;
        p_head_next     = p_head_reg;
        n_cnt_next      = n_cnt_reg;
        p_cnt_next      = p_cnt_reg;
        run_next        = run_reg;
        pend_valid_next = pend_valid_reg;
        pend_pref_next  = pend_pref_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_ticket_next = out_ticket_reg;
        out_pref_next   = out_pref_reg;
        out_last_next   = out_last_reg;

        if (n_wr_en)
        begin
            n_cnt_next = n_cnt_reg + 1'b1;
        end
        if (p_wr_en)
        begin
            p_cnt_next = p_cnt_reg + 1'b1;
        end

        if (issue)
        begin
            pend_valid_next = 1'b1;
            pend_pref_next  = take_pref;
            pend_last_next  = last_pop;
            if (take_pref)
            begin
                p_cnt_next  = p_cnt_reg - 1'b1;
                p_head_next = (p_head_reg == IdxW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : p_head_reg + 1'b1;
                run_next    = (run_reg == RunW'(PREFERRED_RUN)) ? run_reg : run_reg + 1'b1;
            end
            else
            begin
                n_cnt_next  = n_cnt_reg - 1'b1;
                n_head_next = (n_head_reg == IdxW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : n_head_reg + 1'b1;
                run_next    = '0;
            end
            if (last_pop)
            begin
                n_head_next = '0;
                p_head_next = '0;
                run_next    = '0;
            end
        end
        else if (pend_valid_reg && can_load)
        begin
            pend_valid_next = 1'b0;
        end

        priority if (pend_valid_reg && can_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = tctq_pkg::STAT_EMIT;
            out_ticket_next = pend_pref_reg ? p_rd_data : n_rd_data;
            out_pref_next   = pend_pref_reg;
            out_last_next   = pend_last_reg;
        end
        else if (direct_resp)
        begin
            out_valid_next  = 1'b1;
            out_ticket_next = '0;
            out_pref_next   = 1'b0;
            out_last_next   = 1'b1;
            unique case (s_axis_tuser)
                tctq_pkg::CMD_ENQ_NORMAL:
                    out_status_next = n_full ? tctq_pkg::STAT_DROPPED : tctq_pkg::STAT_ACCEPT;
                tctq_pkg::CMD_ENQ_PREF:
                    out_status_next = p_full ? tctq_pkg::STAT_DROPPED : tctq_pkg::STAT_ACCEPT;
                default:
                    out_status_next = tctq_pkg::STAT_EMPTY;
            endcase
        end
        else if (can_load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tctq_pkg::S_IDLE;
            n_head_reg     <= '0;
            p_head_reg     <= '0;
            n_cnt_reg      <= '0;
            p_cnt_reg      <= '0;
            run_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_head_reg     <= n_head_next;
            p_head_reg     <= p_head_next;
            n_cnt_reg      <= n_cnt_next;
            p_cnt_reg      <= p_cnt_next;
            run_reg        <= run_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pref_reg  <= pend_pref_next;
        pend_last_reg  <= pend_last_next;
        out_status_reg <= out_status_next;
        out_ticket_reg <= out_ticket_next;
        out_pref_reg   <= out_pref_next;
        out_last_reg   <= out_last_next;
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_ticket_reg;
    assign m_axis_tuser  = {out_pref_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/tctq_checker.sv -----
// ----------------------------------------------------------------------------
// tctq_checker
// Port-level checks of the two-class ticket queue, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "two_class_ticket_queue_wrr_core_macros.svh"

module tctq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic in_seen;
    assign in_seen = s_axis_tvalid && (s_axis_tdata == s_axis_tdata)
        && (s_axis_tuser == s_axis_tuser);

    // stalled response holds
    `TCTQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // non-drain responses are single, carry no ticket
    `TCTQ_ASSERT_NOW(a_single_resp, m_axis_tvalid && (m_axis_tuser[1:0] != tctq_pkg::STAT_EMIT), m_axis_tlast && (m_axis_tdata == 16'd0) && !m_axis_tuser[2])

    // no new request while a drain is still running
    `TCTQ_ASSERT_NOW(a_drain_blocks, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // only emitted tickets may be non-final (checked while no request is valid)
    `TCTQ_ASSERT_NOW(a_nonlast_emit, m_axis_tvalid && !m_axis_tlast && !in_seen, m_axis_tuser[1:0] == tctq_pkg::STAT_EMIT)

endmodule

bind two_class_ticket_queue_wrr_core tctq_checker u_tctq_checker (.*);

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-class ticket queue with weighted drain.
// ----------------------------------------------------------------------------
// Requests come from a planned list that an initial block fills: a short
// directed opening, then random batches of enqueues closed by a drain, with
// some stray commands mixed in. A queue-based predictor computes every
// response when its request is accepted. The monitor checks each response
// field by field against the oldest prediction. Idle rates change across
// three phases. One phase opens with a long output hold-off that makes the
// block stall its input.
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET = 400;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_TAIL  = 50;

    typedef enum
    {
        PLAN_REQUEST,
        PLAN_PHASE,
        PLAN_HOLD,
        PLAN_SETTLE
    } plan_kind_t;

    typedef struct
    {
        plan_kind_t                      kind;
        logic [tctq_pkg::CMD_W-1:0]      cmd;
        logic [tctq_pkg::TICKET_W-1:0]   ticket;
        int                              send_pct;
        int                              recv_pct;
    } plan_entry_t;

    typedef struct
    {
        logic [tctq_pkg::STATUS_W-1:0]   status;
        logic [tctq_pkg::TICKET_W-1:0]   ticket;
        logic                            pref;
        logic                            last;
    } response_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tctq_pkg::TICKET_W-1:0]   s_axis_tdata = '0;
    logic [tctq_pkg::CMD_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tctq_pkg::TICKET_W-1:0]   m_axis_tdata;
    logic [2:0]                      m_axis_tuser;
    logic                            m_axis_tlast;

    plan_entry_t                     request_plan[$];
    response_t                       owed_responses[$];
    logic [tctq_pkg::TICKET_W-1:0]   normal_tickets[$];
    logic [tctq_pkg::TICKET_W-1:0]   pref_tickets[$];

    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_seq = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;
    int                    mismatch_count = 0;
    int                    request_count = 0;

    two_class_ticket_queue_wrr_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: mismatch: %s", $realtime, what);
    endtask

    task automatic plan_request(input logic [tctq_pkg::CMD_W-1:0] cmd,
                                input logic [tctq_pkg::TICKET_W-1:0] tkt);
        plan_entry_t e;
        e = '{kind: PLAN_REQUEST, cmd: cmd, ticket: tkt, send_pct: 0, recv_pct: 0};
        request_plan.push_back(e);
        if (cmd != tctq_pkg::CMD_UNUSED)
            request_count++;
    endtask

    task automatic plan_marker(input plan_kind_t kind, input int spct, input int rpct);
        plan_entry_t e;
        e = '{kind: kind, cmd: '0, ticket: '0, send_pct: spct, recv_pct: rpct};
        request_plan.push_back(e);
    endtask

    // enqueue then drain in PREFERRED_RUN:1 order; queues end empty
    task automatic predict_tickets(input logic [tctq_pkg::CMD_W-1:0] cmd,
                                   input logic [tctq_pkg::TICKET_W-1:0] tkt);
        response_t r;
        int        run;
        r = '{status: tctq_pkg::STAT_ACCEPT, ticket: '0, pref: 1'b0, last: 1'b1};
        run = 0;
        case (cmd)
            tctq_pkg::CMD_ENQ_NORMAL:
            begin
                if (normal_tickets.size() >= tctq_pkg::QUEUE_DEPTH_DEF)
                    r.status = tctq_pkg::STAT_DROPPED;
                else
                    normal_tickets.push_back(tkt);
                owed_responses.push_back(r);
            end
            tctq_pkg::CMD_ENQ_PREF:
            begin
                if (pref_tickets.size() >= tctq_pkg::QUEUE_DEPTH_DEF)
                    r.status = tctq_pkg::STAT_DROPPED;
                else
                    pref_tickets.push_back(tkt);
                owed_responses.push_back(r);
            end
            tctq_pkg::CMD_DRAIN:
            begin
                if (normal_tickets.size() == 0 && pref_tickets.size() == 0)
                begin
                    r.status = tctq_pkg::STAT_EMPTY;
                    owed_responses.push_back(r);
                end
                while (normal_tickets.size() != 0 || pref_tickets.size() != 0)
                begin
                    r.status = tctq_pkg::STAT_EMIT;
                    if (pref_tickets.size() != 0 &&
                        (run < tctq_pkg::PREFERRED_RUN_DEF || normal_tickets.size() == 0))
                    begin
                        r.ticket = pref_tickets.pop_front();
                        r.pref   = 1'b1;
                        run++;
                    end
                    else
                    begin
                        r.ticket = normal_tickets.pop_front();
                        r.pref   = 1'b0;
                        run      = 0;
                    end
                    r.last = (normal_tickets.size() == 0 && pref_tickets.size() == 0);
                    owed_responses.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        logic accepted;
        logic waiting;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            accepted = s_axis_tvalid && s_axis_tready;
            waiting  = 1'b0;
            if (accepted)
                predict_tickets(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || accepted)
            begin
                while (!waiting && request_plan.size() > 0 &&
                       request_plan[0].kind != PLAN_REQUEST)
                begin
                    case (request_plan[0].kind)
                        PLAN_PHASE:
                        begin
                            send_idle_pct = request_plan[0].send_pct;
                            recv_idle_pct <= request_plan[0].recv_pct;
                            void'(request_plan.pop_front());
                        end
                        PLAN_HOLD:
                        begin
                            hold_seq <= hold_seq + 1;
                            void'(request_plan.pop_front());
                        end
                        default:
                        begin
                            if (owed_responses.size() == 0)
                                void'(request_plan.pop_front());
                            else
                                waiting = 1'b1;
                        end
                    endcase
                end
                if (!waiting && request_plan.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= request_plan[0].cmd;
                    s_axis_tdata  <= request_plan[0].ticket;
                    void'(request_plan.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        response_t r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_responses.size() == 0)
                    report_mismatch("response with none expected");
                else
                begin
                    r = owed_responses.pop_front();
                    if (m_axis_tuser[1:0] !== r.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_axis_tuser[1:0], r.status));
                    if (m_axis_tdata !== r.ticket)
                        report_mismatch($sformatf("ticket %h, expected %h",
                                                  m_axis_tdata, r.ticket));
                    if (m_axis_tuser[2] !== r.pref)
                        report_mismatch($sformatf("preferential %b, expected %b",
                                                  m_axis_tuser[2], r.pref));
                    if (m_axis_tlast !== r.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_axis_tlast, r.last));
                end
            end
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int pref_pct;
        int target;
        logic [tctq_pkg::CMD_W-1:0] cmd;

        // directed opening
        plan_marker(PLAN_PHASE, 22, 77);
        plan_request(tctq_pkg::CMD_DRAIN, 16'h0000);
        plan_request(tctq_pkg::CMD_ENQ_NORMAL, 16'h0000);
        plan_request(tctq_pkg::CMD_ENQ_PREF, 16'hFFFF);
        plan_request(tctq_pkg::CMD_UNUSED, 16'hA5A5);
        plan_request(tctq_pkg::CMD_DRAIN, 16'hFFFF);
        for (int i = 0; i < tctq_pkg::QUEUE_DEPTH_DEF + 1; i++)
            plan_request(tctq_pkg::CMD_ENQ_PREF, 16'(i * 16'h1111));
        plan_request(tctq_pkg::CMD_DRAIN, 16'h5A5A);

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
                plan_marker(PLAN_PHASE, 77, 22);
            if (ph == 2)
            begin
                // output stalled long enough to back up the input
                plan_marker(PLAN_PHASE, 0, 0);
                plan_marker(PLAN_HOLD, 0, 0);
                for (int i = 0; i < 24; i++)
                    plan_request($urandom_range(1) ? tctq_pkg::CMD_ENQ_PREF
                                                   : tctq_pkg::CMD_ENQ_NORMAL,
                                 16'($urandom));
                plan_request(tctq_pkg::CMD_DRAIN, 16'($urandom));
                plan_marker(PLAN_SETTLE, 0, 0);
            end
            target = (ph + 1) * ITEM_TARGET / 3;
            while (request_count < target)
            begin
                n        = ($urandom_range(5) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(0, 20);
                pref_pct = $urandom_range(100);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(99) < 4)
                        cmd = tctq_pkg::CMD_UNUSED;
                    else if ($urandom_range(99) < 3)
                        cmd = tctq_pkg::CMD_DRAIN;
                    else if ($urandom_range(99) < pref_pct)
                        cmd = tctq_pkg::CMD_ENQ_PREF;
                    else
                        cmd = tctq_pkg::CMD_ENQ_NORMAL;
                    plan_request(cmd, 16'($urandom));
                end
                plan_request(tctq_pkg::CMD_DRAIN, 16'($urandom));
                if ($urandom_range(9) == 0)
                    plan_request(tctq_pkg::CMD_DRAIN, 16'($urandom));
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_plan.size() != 0 || s_axis_tvalid || owed_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/tctq_pkg.sv
sv/tctq_ticket_ram.sv
sv/two_class_ticket_queue_wrr_core.sv
sv/tctq_checker.sv
verif/tb.sv
